// ----- design/llns_pkg.sv -----
// Shared types and constants for the least-loaded node selector.
`default_nettype none

package llns_pkg;

  // Operation codes carried in the input beat.
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_PICK   = 1'b1;

  // Configuration register map: one 32-bit register, byte addressed.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_STALE_LIMIT = 1'b0;

  // Reset value of the stale limit, in ticks.
  localparam logic [31:0] STALE_RESET = 32'd10000;

  // One input beat.
  typedef struct packed {
    logic        operation;
    logic [31:0] node_ip;
    logic [31:0] node_load;
    logic [31:0] own_load;
    logic [31:0] now;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] pick_ip;
    logic [31:0] target_load;
    logic        dropped;
  } result_t;

  // One row of the peer table.
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] tasks;
    logic [31:0] stamp;
  } entry_t;

  // Flags that the entry evaluator hands back for one row.
  typedef struct packed {
    logic match;
    logic free;
    logic better;
  } eval_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/llns_eval.sv -----
// Per-row evaluator shared by every step of the table scan.
`default_nettype none

module llns_eval (
  input  llns_pkg::entry_t  entry,
  input  logic              valid,
  input  logic [31:0]       node_ip,
  input  logic [31:0]       now,
  input  logic [31:0]       stale_limit,
  input  logic [31:0]       min_load,
  output llns_pkg::eval_t   flags
);
  import llns_pkg::*;

  logic [31:0] age;

  // Age of the report, modulo 2^32.
  assign age = now - entry.stamp;

  // A row matches the reporting address, is free, or is fresh and beats the best load so far.
  always_comb begin
    flags.match  = valid && (entry.addr == node_ip);
    flags.free   = !valid;
    flags.better = valid && (age <= stale_limit) && (entry.tasks < min_load);
  end

endmodule

`default_nettype wire

// ----- design/least_loaded_node_select.sv -----
// Top level of the least-loaded node selector: peer table, scan sequencer, APB registers.
//
// Usage:
//   Input channel: drive item and raise start; the beat is accepted at a rising
//   edge where start is high and busy is low. item.operation selects a load
//   report or a pick.
//   Output channel: done is high for exactly one cycle with result valid; the
//   receiver takes it in that cycle and cannot stall the block.
//   Every item gives exactly one result beat.
//   Scan: the sequencer reads one table row per cycle from the table memory
//   (one write port, one registered read port) and evaluates each row in the
//   cycle after its read, then passes a tail state and a done state. busy is
//   already low in the cycle in which done is high, so a new item may be
//   accepted while the result is shown.
//   Configuration: stale_limit at byte address 0 over the APB port; write it only
//   while busy is low. pready is tied high.
//   Reset: rst (synchronous) clears all table valid bits, loads stale_limit with
//   10000 and returns the sequencer to idle. No clearing pass is needed.
`default_nettype none

module least_loaded_node_select #(
  parameter int unsigned NODES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // Command channel
  input  logic                          start,
  output logic                          busy,
  input  llns_pkg::item_t               item,
  output logic                          done,
  output llns_pkg::result_t             result,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llns_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import llns_pkg::*;

  localparam int unsigned IDXW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NODES - 1);

  // Sequencer
  state_t state, state_next;
  logic   scan_en, commit;

  // Latched command and running scan results
  item_t          cmd;
  logic [31:0]    min_load;
  logic [31:0]    best_ip;
  logic           hit_found, free_found;
  logic [IDXW-1:0] hit_idx, free_idx;

  // Table storage
  entry_t          mem [NODES];
  logic [NODES-1:0] entry_valid;
  logic [IDXW-1:0] rd_idx, rd_idx_q;
  logic            rd_vld;
  entry_t          rd_entry;
  eval_t           flags;

  // Commit controls
  logic            mem_we;
  logic [IDXW-1:0] wr_idx;
  logic            drop;

  // Configuration
  logic [31:0] stale_limit;
  logic        cfg_wr;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_SCAN;
      S_SCAN: if (rd_idx == LAST_IDX) state_next = S_TAIL;
      S_TAIL: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    commit  = 1'b0;
    case (state)
      S_IDLE: busy    = 1'b0;
      S_SCAN: scan_en = 1'b1;
      S_TAIL: ;
      S_DONE: commit  = 1'b1;
      default: busy   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Read index and read-data qualifier for the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scan_en;
      if (scan_en) begin
        rd_idx <= rd_idx + 1'b1;
      end else begin
        rd_idx <= '0;
      end
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= '{addr: cmd.node_ip, tasks: cmd.node_load, stamp: cmd.now};
    end
    if (scan_en) begin
      rd_entry <= mem[rd_idx];
      rd_idx_q <= rd_idx;
    end
  end

  // Shared row evaluator.
  llns_eval u_eval (
    .entry       (rd_entry),
    .valid       (entry_valid[rd_idx_q]),
    .node_ip     (cmd.node_ip),
    .now         (cmd.now),
    .stale_limit (stale_limit),
    .min_load    (min_load),
    .flags       (flags)
  );

  // Command latch and running best / first-hit / first-free tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (start && !busy) begin
      cmd        <= item;
      min_load   <= item.own_load;
      best_ip    <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (cmd.operation == OP_PICK) begin
        if (flags.better) begin
          min_load <= rd_entry.tasks;
          best_ip  <= rd_entry.addr;
        end
      end else begin
        if (flags.match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx_q;
        end
        if (flags.free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx_q;
        end
      end
    end
  end

  // Commit decision for a report: refresh a hit, else fill the first free row, else drop it.
  assign mem_we = commit && (cmd.operation == OP_REPORT) && (hit_found || free_found);
  assign wr_idx = hit_found ? hit_idx : free_idx;
  assign drop   = !hit_found && !free_found;

  // Valid bits live in flops and clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we && !hit_found) begin
      entry_valid[wr_idx] <= 1'b1;
    end
  end

  // Result register and one-cycle strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= commit;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (cmd.operation == OP_PICK) begin
        result <= '{pick_ip: best_ip, target_load: min_load, dropped: 1'b0};
      end else begin
        result <= '{pick_ip: '0, target_load: '0, dropped: drop};
      end
    end
  end

  // APB register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_RESET;
    end else if (cfg_wr && (paddr[2] == REG_STALE_LIMIT)) begin
      stale_limit <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_STALE_LIMIT) ? stale_limit : '0;

endmodule

`default_nettype wire

// ----- design/llns_checker.sv -----
// Port-level checks on the least-loaded node selector, bound to its top level.
`default_nettype none

module llns_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input llns_pkg::result_t  result
);
  import llns_pkg::*;

  // An accepted beat makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // A result is shown only once the block has gone idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result shown while busy or without prior work");

  // The result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // A dropped report carries no target.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.dropped |-> (result.pick_ip == '0) && (result.target_load == '0))
    else $error("dropped report with nonzero target fields");

endmodule

bind least_loaded_node_select llns_checker u_llns_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
